>>> rtl/kmp_pattern_matcher_macros.svh
// Assertion helpers for the pattern matcher.
`ifndef KMP_PATTERN_MATCHER_MACROS_SVH
`define KMP_PATTERN_MATCHER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define KMP_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define KMP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define KMP_ASSERT_NOW(lbl, clk, rst, ante, cons, msg)
`define KMP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

>>> rtl/kmp_pkg.sv
package kmp_pkg;

   localparam int MAX_PATTERN = 256;
   localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
   localparam int LINE_W      = 24;
   localparam int POS_W       = 16;
   localparam int BYTE_W      = 8;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_TEXT   = 2'd2,
      OP_EOL    = 2'd3
   } opcode_type;

   typedef struct packed {
      opcode_type        opcode;
      logic [BYTE_W-1:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [LINE_W-1:0] line_number;
      logic [POS_W-1:0]  match_position;
   } rsp_type;

   // One write into both pattern and prefix tables at the same index.
   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  addr;
      logic [BYTE_W-1:0] pat;
      logic [IDX_W-1:0]  border;
   } kmp_wr_type;

endpackage

>>> rtl/kmp_store.sv
module kmp_store
   import kmp_pkg::*;
(
   input  logic              clock,
   input  kmp_wr_type        wr,
   input  logic [IDX_W-1:0]  pat_raddr,
   input  logic [IDX_W-1:0]  pfx_raddr,
   output logic [BYTE_W-1:0] pat_rd_ff,
   output logic [IDX_W-1:0]  pfx_rd_ff
);

   logic [BYTE_W-1:0] pattern_mem [MAX_PATTERN];
   logic [IDX_W-1:0]  prefix_mem  [MAX_PATTERN];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         pattern_mem[wr.addr] <= wr.pat;
         prefix_mem[wr.addr]  <= wr.border;
      end
   end

   always_ff @(posedge clock) begin
      pat_rd_ff <= pattern_mem[pat_raddr];
      pfx_rd_ff <= prefix_mem[pfx_raddr];
   end

endmodule

>>> rtl/kmp_pattern_matcher.sv
// Streaming Knuth-Morris-Pratt matcher. Clear, end-of-line, the first pattern
// byte, an append to a full pattern and a text byte against an empty pattern
// are handled in the idle state. Any other append or text byte makes P
// prefix-table probes, each one registered read of the pattern and prefix
// memories, then one compare; P is the fallback count plus one and averages
// under two per text byte. req_ready is high only while the sequencer is
// idle. A match is held in an output register until taken; a text byte that
// matches waits for that register to free up.
`include "kmp_pattern_matcher_macros.svh"

module kmp_pattern_matcher
   import kmp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_TEST
   } state_type;

   state_type         state_ff, state_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [IDX_W-1:0]  border_ff, border_in;
   logic [LEN_W-1:0]  matched_ff, matched_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [LINE_W-1:0] line_ff, line_in;
   logic [LEN_W-1:0]  k_ff, k_in;
   logic [LEN_W-1:0]  lim_ff, lim_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   opcode_type        op_ff, op_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   kmp_wr_type        wr;
   logic [BYTE_W-1:0] pat_rd;
   logic [IDX_W-1:0]  pfx_rd;
   logic [LEN_W-1:0]  k_dec;
   logic [LEN_W-1:0]  k_next;
   logic              probe_hit;
   logic              keep_falling;
   logic              out_free;

   kmp_store u_store (
      .clock     (clock),
      .wr        (wr),
      .pat_raddr (k_ff[IDX_W-1:0]),
      .pfx_raddr (k_dec[IDX_W-1:0]),
      .pat_rd_ff (pat_rd),
      .pfx_rd_ff (pfx_rd)
   );

   assign k_dec        = k_ff - 1'b1;
   assign probe_hit    = (k_ff < lim_ff) && (pat_rd == byte_ff);
   assign keep_falling = (k_ff != '0) && (k_ff <= lim_ff) &&
                         ((k_ff >= lim_ff) || (pat_rd != byte_ff));
   assign k_next       = probe_hit ? (k_ff + 1'b1) : k_ff;
   assign out_free     = !rsp_valid_ff || rsp_ready;

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      border_in    = border_ff;
      matched_in   = matched_ff;
      pos_in       = pos_ff;
      line_in      = line_ff;
      k_in         = k_ff;
      lim_in       = lim_ff;
      byte_in      = byte_ff;
      op_in        = op_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      wr           = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_payload.opcode)
                  OP_CLEAR: begin
                     len_in     = '0;
                     border_in  = '0;
                     matched_in = '0;
                     pos_in     = '0;
                     line_in    = LINE_W'(1);
                  end
                  OP_APPEND: begin
                     if (len_ff == LEN_W'(MAX_PATTERN)) begin
                        // drop: pattern full
                     end else if (len_ff == '0) begin
                        wr.en     = 1'b1;
                        wr.addr   = '0;
                        wr.pat    = req_payload.data_byte;
                        wr.border = '0;
                        border_in = '0;
                        len_in    = LEN_W'(1);
                     end else begin
                        k_in     = LEN_W'(border_ff);
                        lim_in   = len_ff;
                        byte_in  = req_payload.data_byte;
                        op_in    = OP_APPEND;
                        state_in = ST_FETCH;
                     end
                  end
                  OP_TEXT: begin
                     if (len_ff == '0) begin
                        if (pos_ff != '1) begin
                           pos_in = pos_ff + 1'b1;
                        end
                     end else begin
                        k_in     = matched_ff;
                        lim_in   = len_ff;
                        byte_in  = req_payload.data_byte;
                        op_in    = OP_TEXT;
                        state_in = ST_FETCH;
                     end
                  end
                  OP_EOL: begin
                     matched_in = '0;
                     pos_in     = '0;
                     line_in    = line_ff + 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FETCH: begin
            // wait for the registered table reads at k
            state_in = ST_TEST;
         end
         ST_TEST: begin
            if (keep_falling) begin
               k_in     = LEN_W'(pfx_rd);
               state_in = ST_FETCH;
            end else if (k_ff > lim_ff) begin
               k_in     = '0;
               state_in = ST_FETCH;
            end else if (op_ff == OP_APPEND) begin
               wr.en     = 1'b1;
               wr.addr   = lim_ff[IDX_W-1:0];
               wr.pat    = byte_ff;
               wr.border = k_next[IDX_W-1:0];
               border_in = k_next[IDX_W-1:0];
               len_in    = lim_ff + 1'b1;
               state_in  = ST_IDLE;
            end else if (out_free || (k_next != lim_ff)) begin
               matched_in = k_next;
               if (k_next == lim_ff) begin
                  rsp_valid_in                = 1'b1;
                  rsp_data_in.line_number     = line_ff;
                  rsp_data_in.match_position  = pos_ff;
               end
               if (pos_ff != '1) begin
                  pos_in = pos_ff + 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         border_ff    <= '0;
         matched_ff   <= '0;
         pos_ff       <= '0;
         line_ff      <= LINE_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         border_ff    <= border_in;
         matched_ff   <= matched_in;
         pos_ff       <= pos_in;
         line_ff      <= line_in;
         rsp_valid_ff <= rsp_valid_in;
         k_ff         <= k_in;
         lim_ff       <= lim_in;
         byte_ff      <= byte_in;
         op_ff        <= op_in;
         rsp_data_ff  <= rsp_data_in;
      end
   end

   `KMP_ASSERT_NOW(a_matched_in_range, clock, reset, 1'b1, matched_ff <= len_ff, "match count beyond pattern length")
   `KMP_ASSERT_NOW(a_border_proper, clock, reset, len_ff != '0, LEN_W'(border_ff) < len_ff, "build border not a proper border")
   `KMP_ASSERT_NOW(a_probe_in_range, clock, reset, state_ff != ST_IDLE, k_ff <= lim_ff, "fallback index beyond limit")
   `KMP_ASSERT_NEXT(a_match_waits, clock, reset, rsp_valid_ff && !rsp_ready, rsp_valid_ff, "pending match dropped")

endmodule
